>>> hdl/tad_pkg.sv
// Shared types, constants and the first-octant arctangent table.
`timescale 1ns / 1ps
package tad_pkg;

    localparam int IN_W    = 16;
    localparam int MAG_W   = 15;
    localparam int ANGLE_W = 9;
    localparam int Q_W     = 6;
    localparam int ROM_W   = 6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // 180/pi with 24 fraction bits; narrower scalings round from it.
    localparam longint unsigned RAD2DEG_Q24 = 64'd961263669;

    localparam logic [Q_W-1:0]     ROM_LAST = 6'd57;
    localparam logic [MAG_W-1:0]   MAG_MAX  = 15'h7FFF;
    localparam logic [ANGLE_W-1:0] DEG_90   = 9'd90;
    localparam logic [ANGLE_W-1:0] DEG_180  = 9'd180;
    localparam logic [ANGLE_W-1:0] DEG_360  = 9'd360;

    // Entry i is round(atan(i*pi/180)*180/pi).
    localparam logic [ROM_W-1:0] ATAN_ROM [0:57] = '{
        6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd17, 6'd18,
        6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd28, 6'd29, 6'd30, 6'd31, 6'd31, 6'd32, 6'd33, 6'd34, 6'd34,
        6'd35, 6'd36, 6'd36, 6'd37, 6'd38, 6'd38, 6'd39, 6'd39, 6'd40, 6'd41,
        6'd41, 6'd42, 6'd42, 6'd43, 6'd43, 6'd44, 6'd44, 6'd45
    };

    typedef struct packed {
        logic swap;
        logic neg_x;
        logic neg_y;
        logic zero;
    } t_meta;

    typedef struct packed {
        logic [MAG_W-1:0] lesser;
        logic [MAG_W-1:0] big;
        t_meta            meta;
    } t_item;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
    } t_q_status;

endpackage

>>> hdl/tad_in_if.sv
// Input channel: one vector (dy, dx) per transaction.
`timescale 1ns / 1ps
interface tad_in_if;
    import tad_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] dy;
    logic signed [IN_W-1:0] dx;

    modport source (output valid, output dy, output dx, input ready);
    modport sink   (input valid, input dy, input dx, output ready);
endinterface

>>> hdl/tad_out_if.sv
// Output channel: one angle in degrees per transaction.
`timescale 1ns / 1ps
interface tad_out_if;
    import tad_pkg::*;

    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

>>> hdl/tad_front.sv
// Front end: takes magnitudes and signs, orders the two magnitudes, flags the zero vector.
`timescale 1ns / 1ps
module tad_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [tad_pkg::IN_W-1:0] i_dy,
    input  logic signed [tad_pkg::IN_W-1:0] i_dx,
    output logic                            o_valid,
    input  logic                            i_ready,
    output tad_pkg::t_item                  o_item
);
    import tad_pkg::*;

    logic             r_valid;
    t_item            r_item;
    t_item            n_item;
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] ax;
    logic             load;

    function automatic logic [MAG_W-1:0] magnitude(input logic [IN_W-1:0] raw);
        logic [IN_W-1:0] neg;
        neg = -raw;
        if (!raw[IN_W-1]) begin
            return raw[MAG_W-1:0];
        end else if (neg[IN_W-1]) begin
            // The most negative code saturates to the largest magnitude.
            return MAG_MAX;
        end else begin
            return neg[MAG_W-1:0];
        end
    endfunction

    assign ay = magnitude(i_dy);
    assign ax = magnitude(i_dx);

    always_comb begin
        n_item.meta.swap  = ay > ax;
        n_item.meta.neg_x = i_dx[IN_W-1];
        n_item.meta.neg_y = i_dy[IN_W-1];
        n_item.meta.zero  = (ay == '0) && (ax == '0);
        n_item.lesser     = n_item.meta.swap ? ax : ay;
        n_item.big        = n_item.meta.swap ? ay : ax;
    end

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end
endmodule

>>> hdl/tad_queue.sv
// Short queue that decouples the front end from the arithmetic back end.
`timescale 1ns / 1ps
module tad_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  tad_pkg::t_item     i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output tad_pkg::t_item     o_item,
    output tad_pkg::t_q_status o_status
);
    import tad_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    assign o_status.count = r_count;
    assign o_status.full  = !o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end
endmodule

>>> hdl/tad_back.sv
// Back end: scaled numerator, pipelined restoring divider, table lookup and quadrant fold.
`timescale 1ns / 1ps
module tad_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  tad_pkg::t_item                i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tad_pkg::ANGLE_W-1:0]   o_angle
);
    import tad_pkg::*;

    localparam longint unsigned K_VAL =
        (((RAD2DEG_Q24 * 2) >> (24 - FRAC_BITS)) + 1) >> 1;
    localparam int K_W    = $clog2(K_VAL + 1);
    localparam int PROD_W = MAG_W + K_W;
    localparam int DEN_W  = MAG_W + FRAC_BITS;
    localparam int NUM_W  = ((PROD_W > DEN_W - 1) ? PROD_W : DEN_W - 1) + 1;
    localparam int DIV_W  = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
    localparam logic [K_W-1:0] K_VEC = K_VAL[K_W-1:0];

    logic en;

    // Multiply stage.
    logic              r_v_mul;
    logic [PROD_W-1:0] r_prod;
    logic [MAG_W-1:0]  r_big_mul;
    t_meta             r_meta_mul;

    // Numerator and denominator stage.
    logic              r_v_add;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    t_meta             r_meta_add;

    // Divider stages, one quotient bit each, most significant first.
    logic              r_v_div    [Q_W];
    logic [Q_W-1:0]    r_q        [Q_W];
    t_meta             r_meta_div [Q_W];
    logic [DIV_W-1:0]  r_rem      [Q_W-1];
    logic [DEN_W-1:0]  r_den_div  [Q_W-1];

    // Output stage.
    logic               r_out_valid;
    logic [ANGLE_W-1:0] r_angle;
    logic [ANGLE_W-1:0] n_angle;

    // The whole back end advances together whenever the output slot is free.
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_valid;
    assign o_angle = r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mul <= 1'b0;
            r_v_add <= 1'b0;
        end else if (en) begin
            r_v_mul <= i_valid;
            r_v_add <= r_v_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod     <= {{K_W{1'b0}}, i_item.lesser} * {{MAG_W{1'b0}}, K_VEC};
            r_big_mul  <= i_item.big;
            r_meta_mul <= i_item.meta;
            // Adding half the denominator makes the floor round half up.
            r_num      <= NUM_W'(r_prod) + (NUM_W'(r_big_mul) << (FRAC_BITS - 1));
            r_den      <= DEN_W'(r_big_mul) << FRAC_BITS;
            r_meta_add <= r_meta_mul;
        end
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        logic [DIV_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   q_in;
        t_meta            meta_in;
        logic             v_in;
        logic [DIV_W-1:0] trial;
        logic             fits;

        if (j == 0) begin : g_first
            assign rem_in  = DIV_W'(r_num);
            assign den_in  = r_den;
            assign q_in    = '0;
            assign meta_in = r_meta_add;
            assign v_in    = r_v_add;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign den_in  = r_den_div[j-1];
            assign q_in    = r_q[j-1];
            assign meta_in = r_meta_div[j-1];
            assign v_in    = r_v_div[j-1];
        end

        assign trial = DIV_W'(den_in) << (Q_W - 1 - j);
        assign fits  = rem_in >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v_div[j] <= 1'b0;
            end else if (en) begin
                r_v_div[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_q[j]        <= q_in | (fits ? (Q_W'(1) << (Q_W - 1 - j)) : '0);
                r_meta_div[j] <= meta_in;
            end
        end

        if (j < Q_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[j]     <= fits ? rem_in - trial : rem_in;
                    r_den_div[j] <= den_in;
                end
            end
        end
    end

    always_comb begin
        logic [Q_W-1:0]     idx;
        logic [ANGLE_W-1:0] rom;
        logic [ANGLE_W-1:0] oct;
        logic [ANGLE_W-1:0] half;
        logic [ANGLE_W-1:0] full;
        t_meta              m;
        m    = r_meta_div[Q_W-1];
        idx  = (r_q[Q_W-1] > ROM_LAST) ? ROM_LAST : r_q[Q_W-1];
        rom  = ANGLE_W'(ATAN_ROM[idx]);
        if (m.zero) begin
            oct = DEG_90;
        end else if (m.swap) begin
            oct = DEG_90 - rom;
        end else begin
            oct = rom;
        end
        half    = m.neg_x ? DEG_180 - oct : oct;
        full    = m.neg_y ? DEG_360 - half : half;
        n_angle = (full == DEG_360) ? '0 : full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v_div[Q_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_angle <= n_angle;
        end
    end
endmodule

>>> hdl/table_atan2_degrees_core.sv
// Top level of the table-based integer-degree arctangent.
//
// Each input transaction carries a signed vector (dy, dx); each output transaction carries
// its angle in whole degrees, 0 to 359, counterclockwise from the positive x axis, in the
// order the vectors arrived. A zero vector gives 90, and -32768 is taken as -32767. One
// vector is accepted per clock cycle and one angle is delivered per cycle while the output
// side takes them. A vector passes the front end register, the queue, then in the back end
// the multiply stage, the numerator add stage, six restoring divide stages (one quotient bit
// each) and the lookup and fold register. The four-entry queue lets the front end keep
// accepting while the output is stalled, until the queue fills. FRAC_BITS (12 to 24) sets
// the fraction bits of the 180/pi scale factor and thereby the width of the multiplier and
// the divider datapath.
`timescale 1ns / 1ps
module table_atan2_degrees_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tad_in_if.sink           i_in,
    tad_out_if.source        o_out
);
    import tad_pkg::*;

    logic      f_valid;
    logic      f_ready;
    t_item     f_item;
    logic      q_valid;
    logic      q_ready;
    t_item     q_item;
    t_q_status q_status;

    tad_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_dy    (i_in.dy),
        .i_dx    (i_in.dx),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item)
    );

    tad_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (f_valid),
        .o_ready  (f_ready),
        .i_item   (f_item),
        .o_valid  (q_valid),
        .i_ready  (q_ready),
        .o_item   (q_item),
        .o_status (q_status)
    );

    tad_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_angle (o_out.angle)
    );

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.angle < DEG_360))
        else $error("angle out of range");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_queue_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (({1'b0, q_status.count} <= {1'b0, $past(q_status.count)} + 1'b1)
              && ({1'b0, q_status.count} + 1'b1 >= {1'b0, $past(q_status.count)})))
        else $error("queue count moved by more than one");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.full && !q_ready) |=> (q_status.count == QCNT_W'(QUEUE_DEPTH)))
        else $error("full queue lost an entry without a pop");
endmodule
